/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define CHECK_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CHECK_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/plca_pkg.sv */
// Package: shared constants and types of the polyline crop block
`timescale 1ns / 1ps
package plca_pkg;

   localparam int DEF_COORD_WIDTH = 32;
   localparam int DEF_FRAC_BITS   = 16;
   localparam int QUEUE_DEPTH     = 2;
   localparam int NUM_AXES        = 3;

   typedef enum logic [1:0] {
      KIND_FIRST = 2'd0,
      KIND_PASS  = 2'd1,
      KIND_SEG   = 2'd2
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic          last;
   } item_ctl_type;

endpackage

/* rtl/plca_front.sv */
// Front end: vertex intake, path classification and transaction queue
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plca_front #(
   parameter int COORD_WIDTH = plca_pkg::DEF_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   input  logic signed [COORD_WIDTH-1:0] req_crop_length,
   input  logic                          req_path_end,
   output logic                          q_valid,
   input  logic                          q_ready,
   output plca_pkg::item_ctl_type        q_ctl,
   output logic signed [COORD_WIDTH-1:0] q_x,
   output logic signed [COORD_WIDTH-1:0] q_y,
   output logic signed [COORD_WIDTH-1:0] q_z,
   output logic signed [COORD_WIDTH-1:0] q_crop
);

   localparam int W    = COORD_WIDTH;
   localparam int QD   = plca_pkg::QUEUE_DEPTH;
   localparam int PTRW = (QD > 1) ? $clog2(QD) : 1;
   localparam int CNTW = $clog2(QD + 1);

   logic signed [W-1:0]    x_mem [QD];
   logic signed [W-1:0]    y_mem [QD];
   logic signed [W-1:0]    z_mem [QD];
   logic signed [W-1:0]    crop_mem [QD];
   plca_pkg::item_ctl_type ctl_mem [QD];

   logic [PTRW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] q_count_ff, q_count_in;
   logic            first_pending_ff, first_pending_in;
   logic            crop_neg_ff, crop_neg_in;
   logic            push, pop;
   plca_pkg::item_ctl_type new_ctl;

   assign req_ready = (q_count_ff != CNTW'(QD));
   assign push      = req_valid && req_ready;
   assign q_valid   = (q_count_ff != '0);
   assign pop       = q_valid && q_ready;

   always_comb begin
      new_ctl.last = req_path_end;
      if (first_pending_ff) begin
         new_ctl.kind = plca_pkg::KIND_FIRST;
      end else if (crop_neg_ff) begin
         new_ctl.kind = plca_pkg::KIND_PASS;
      end else begin
         new_ctl.kind = plca_pkg::KIND_SEG;
      end
   end

   always_comb begin
      wr_ptr_in        = wr_ptr_ff;
      rd_ptr_in        = rd_ptr_ff;
      q_count_in       = q_count_ff;
      first_pending_in = first_pending_ff;
      crop_neg_in      = crop_neg_ff;
      if (push) begin
         wr_ptr_in        = (wr_ptr_ff == PTRW'(QD - 1)) ? '0 : wr_ptr_ff + 1'b1;
         first_pending_in = req_path_end;
         if (first_pending_ff) begin
            crop_neg_in = req_crop_length[W-1];
         end
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(QD - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         q_count_in = q_count_ff + 1'b1;
      end else if (pop && !push) begin
         q_count_in = q_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         q_count_ff       <= '0;
         first_pending_ff <= 1'b1;
         crop_neg_ff      <= 1'b0;
      end else begin
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         q_count_ff       <= q_count_in;
         first_pending_ff <= first_pending_in;
         crop_neg_ff      <= crop_neg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         x_mem[wr_ptr_ff]    <= req_point_x;
         y_mem[wr_ptr_ff]    <= req_point_y;
         z_mem[wr_ptr_ff]    <= req_point_z;
         crop_mem[wr_ptr_ff] <= req_crop_length;
         ctl_mem[wr_ptr_ff]  <= new_ctl;
      end
   end

   assign q_x    = x_mem[rd_ptr_ff];
   assign q_y    = y_mem[rd_ptr_ff];
   assign q_z    = z_mem[rd_ptr_ff];
   assign q_crop = crop_mem[rd_ptr_ff];
   assign q_ctl  = ctl_mem[rd_ptr_ff];

   `CHECK_ALWAYS(a_count_range, clock, reset, q_count_ff <= CNTW'(QD), "queue count overflow")
   `CHECK_NEXT(a_count_grow, clock, reset, push && !pop, q_count_ff == $past(q_count_ff) + 1'b1, "queue count did not grow on push")

endmodule

/* rtl/plca_back.sv */
// Back end: segment length, crop point arithmetic and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plca_back #(
   parameter int COORD_WIDTH = plca_pkg::DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = plca_pkg::DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  plca_pkg::item_ctl_type        q_ctl,
   input  logic signed [COORD_WIDTH-1:0] q_x,
   input  logic signed [COORD_WIDTH-1:0] q_y,
   input  logic signed [COORD_WIDTH-1:0] q_z,
   input  logic signed [COORD_WIDTH-1:0] q_crop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z,
   output logic                          rsp_is_crop_point,
   output logic                          rsp_out_last
);

   localparam int W    = COORD_WIDTH;
   localparam int DW   = W + 1;          // coordinate difference / magnitude
   localparam int K    = W + 2;          // segment length
   localparam int PW   = 2 * DW;         // product
   localparam int SUMW = 2 * K;          // sum of three squares
   localparam int RRW  = K + 3;          // square root remainder
   localparam int CNTW = $clog2(K + 1);
   localparam int NA   = plca_pkg::NUM_AXES;
   localparam int AXW  = $clog2(NA);
   localparam int CMPW = (SUMW > 64) ? SUMW : 64;
   localparam longint unsigned NEAR_L = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
   localparam logic [CMPW-1:0] NEAR_P1 = CMPW'(NEAR_L + 64'd1);
   localparam logic [CMPW-1:0] NEAR_SQ = NEAR_P1 * NEAR_P1;
   localparam logic [W-1:0]    LEN_MAX = {1'b0, {(W-1){1'b1}}};

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_SQ_MUL   = 12'b0000_0000_0010,
      S_SQ_ACC   = 12'b0000_0000_0100,
      S_ROOT     = 12'b0000_0000_1000,
      S_DECIDE   = 12'b0000_0001_0000,
      S_CUT_MUL  = 12'b0000_0010_0000,
      S_DIV_LOAD = 12'b0000_0100_0000,
      S_DIV      = 12'b0000_1000_0000,
      S_OFF_MUL  = 12'b0001_0000_0000,
      S_OFF_ACC  = 12'b0010_0000_0000,
      S_SEND0    = 12'b0100_0000_0000,
      S_SEND1    = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic signed [W-1:0]  prev_ff [NA];
   logic signed [W-1:0]  prev_in [NA];
   logic signed [W-1:0]  cur_ff [NA];
   logic signed [W-1:0]  cur_in [NA];
   logic signed [W-1:0]  end_ff [NA];
   logic signed [W-1:0]  end_in [NA];
   logic signed [DW-1:0] d_ff [NA];
   logic signed [DW-1:0] d_in [NA];
   logic signed [W-1:0]  q_pt [NA];

   logic [W-1:0]    run_ff, run_in, crop_ff, crop_in, rem_ff, rem_in;
   logic            cut_ff, cut_in, far_ff, far_in, last_ff, last_in;
   logic [SUMW-1:0] acc_ff, acc_in, rad_ff, rad_in;
   logic [PW-1:0]   prod_ff, prod_in;
   logic [K-1:0]    root_ff, root_in;
   logic [RRW-1:0]  rrem_ff, rrem_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [AXW-1:0]  axis_ff, axis_in;
   logic [K:0]      part_ff, part_in;
   logic [DW-1:0]   dvd_ff, dvd_in, quo_ff, quo_in;

   logic signed [W-1:0] res_pt_ff [2][NA];
   logic signed [W-1:0] res_pt_in [2][NA];
   logic [1:0]          res_crop_ff, res_crop_in, res_last_ff, res_last_in;
   logic                two_ff, two_in;

   logic signed [W-1:0] out_pt_ff [NA];
   logic signed [W-1:0] out_pt_in [NA];
   logic                out_crop_ff, out_crop_in, out_last_ff, out_last_in;
   logic                out_valid_ff, out_valid_in, out_free;

   // datapath
   logic [DW-1:0]       mul_a, mul_b, mag_sel;
   logic signed [DW-1:0] d_sel;
   logic signed [W-1:0] prev_sel;
   logic [SUMW-1:0]     acc_sum;
   logic [K:0]          run_sum;
   logic                take_cut, far_seg, far_cut, root_ge, div_ge, last_axis;
   logic [W-1:0]        rem_c;
   logic [RRW-1:0]      rr, trial;
   logic [K:0]          pp;
   logic signed [W+1:0] pe, qe, endc;

   assign q_pt[0] = q_x;
   assign q_pt[1] = q_y;
   assign q_pt[2] = q_z;

   assign d_sel     = d_ff[axis_ff];
   assign prev_sel  = prev_ff[axis_ff];
   assign mag_sel   = d_sel[DW-1] ? DW'(-d_sel) : DW'(d_sel);
   assign last_axis = (axis_ff == AXW'(NA - 1));
   assign acc_sum   = acc_ff + SUMW'(prod_ff);
   assign run_sum   = (K+1)'(run_ff) + (K+1)'(root_ff);
   assign take_cut  = run_sum > (K+1)'(crop_ff);
   assign rem_c     = crop_ff - run_ff;
   assign far_seg   = 64'(root_ff) > 64'(NEAR_L);
   assign far_cut   = CMPW'(acc_sum) >= NEAR_SQ;
   assign out_free  = !out_valid_ff || rsp_ready;

   // one digit of the square root per cycle
   assign rr      = {rrem_ff[RRW-3:0], rad_ff[SUMW-1 -: 2]};
   assign trial   = RRW'({root_ff, 2'b01});
   assign root_ge = rr >= trial;

   // one quotient bit per cycle
   assign pp     = {part_ff[K-1:0], dvd_ff[DW-1]};
   assign div_ge = pp >= (K+1)'(root_ff);

   assign pe   = (W+2)'(prev_sel);
   assign qe   = (W+2)'(quo_ff);
   assign endc = d_sel[DW-1] ? pe - qe : pe + qe;

   always_comb begin
      mul_a = mag_sel;
      mul_b = mag_sel;
      case (state_ff)
         S_CUT_MUL: begin
            mul_a = DW'(rem_ff);
            mul_b = mag_sel;
         end
         S_OFF_MUL: begin
            mul_a = quo_ff;
            mul_b = quo_ff;
         end
         default: begin
            mul_a = mag_sel;
            mul_b = mag_sel;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      prev_in     = prev_ff;
      cur_in      = cur_ff;
      end_in      = end_ff;
      d_in        = d_ff;
      run_in      = run_ff;
      crop_in     = crop_ff;
      rem_in      = rem_ff;
      cut_in      = cut_ff;
      far_in      = far_ff;
      last_in     = last_ff;
      acc_in      = acc_ff;
      rad_in      = rad_ff;
      prod_in     = prod_ff;
      root_in     = root_ff;
      rrem_in     = rrem_ff;
      cnt_in      = cnt_ff;
      axis_in     = axis_ff;
      part_in     = part_ff;
      dvd_in      = dvd_ff;
      quo_in      = quo_ff;
      res_pt_in   = res_pt_ff;
      res_crop_in = res_crop_ff;
      res_last_in = res_last_ff;
      two_in      = two_ff;
      out_pt_in   = out_pt_ff;
      out_crop_in = out_crop_ff;
      out_last_in = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      q_ready     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               case (q_ctl.kind)
                  plca_pkg::KIND_FIRST: begin
                     crop_in = q_crop;
                     prev_in = q_pt;
                     run_in  = '0;
                     cut_in  = 1'b0;
                     if (q_ctl.last) begin
                        res_pt_in[0] = q_pt;
                        res_crop_in  = 2'b00;
                        res_last_in  = 2'b01;
                        two_in       = 1'b0;
                        state_in     = S_SEND0;
                     end
                  end
                  plca_pkg::KIND_PASS: begin
                     res_pt_in[0] = prev_ff;
                     res_pt_in[1] = q_pt;
                     res_crop_in  = 2'b00;
                     res_last_in  = 2'b10;
                     two_in       = q_ctl.last;
                     if (!q_ctl.last) begin
                        prev_in = q_pt;
                     end
                     state_in = S_SEND0;
                  end
                  plca_pkg::KIND_SEG: begin
                     if (cut_ff) begin
                        if (q_ctl.last) begin
                           res_pt_in[0] = prev_ff;
                           res_pt_in[1] = end_ff;
                           res_crop_in  = 2'b10;
                           res_last_in  = {1'b1, !far_ff};
                           two_in       = far_ff;
                           state_in     = S_SEND0;
                        end
                     end else begin
                        cur_in  = q_pt;
                        last_in = q_ctl.last;
                        for (int a = 0; a < NA; a++) begin
                           d_in[a] = DW'(q_pt[a]) - DW'(prev_ff[a]);
                        end
                        acc_in   = '0;
                        axis_in  = '0;
                        state_in = S_SQ_MUL;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SQ_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            acc_in  = acc_sum;
            axis_in = axis_ff + 1'b1;
            if (last_axis) begin
               rad_in   = acc_sum;
               root_in  = '0;
               rrem_in  = '0;
               cnt_in   = '0;
               state_in = S_ROOT;
            end else begin
               state_in = S_SQ_MUL;
            end
         end
         S_ROOT: begin
            rad_in  = {rad_ff[SUMW-3:0], 2'b00};
            rrem_in = root_ge ? rr - trial : rr;
            root_in = {root_ff[K-2:0], root_ge};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(K - 1)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (take_cut) begin
               rem_in   = rem_c;
               cut_in   = 1'b1;
               axis_in  = '0;
               acc_in   = '0;
               state_in = S_CUT_MUL;
            end else begin
               run_in = (run_sum > (K+1)'(LEN_MAX)) ? LEN_MAX : run_sum[W-1:0];
               res_pt_in[0] = prev_ff;
               res_pt_in[1] = cur_ff;
               res_crop_in  = 2'b00;
               if (last_ff) begin
                  res_last_in = {1'b1, !far_seg};
                  two_in      = far_seg;
               end else begin
                  res_last_in = 2'b00;
                  two_in      = 1'b0;
                  prev_in     = cur_ff;
               end
               state_in = S_SEND0;
            end
         end
         S_CUT_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = S_DIV_LOAD;
         end
         S_DIV_LOAD: begin
            part_in  = (K+1)'(prod_ff[PW-1:DW]);
            dvd_in   = prod_ff[DW-1:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            part_in = div_ge ? pp - (K+1)'(root_ff) : pp;
            dvd_in  = {dvd_ff[DW-2:0], 1'b0};
            quo_in  = {quo_ff[DW-2:0], div_ge};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(DW - 1)) begin
               state_in = S_OFF_MUL;
            end
         end
         S_OFF_MUL: begin
            end_in[axis_ff] = endc[W-1:0];
            prod_in         = mul_a * mul_b;
            state_in        = S_OFF_ACC;
         end
         S_OFF_ACC: begin
            acc_in  = acc_sum;
            axis_in = axis_ff + 1'b1;
            if (last_axis) begin
               far_in = far_cut;
               if (last_ff) begin
                  res_pt_in[0] = prev_ff;
                  res_pt_in[1] = end_ff;
                  res_crop_in  = 2'b10;
                  res_last_in  = {1'b1, !far_cut};
                  two_in       = far_cut;
                  state_in     = S_SEND0;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_CUT_MUL;
            end
         end
         S_SEND0: begin
            if (out_free) begin
               out_pt_in    = res_pt_ff[0];
               out_crop_in  = res_crop_ff[0];
               out_last_in  = res_last_ff[0];
               out_valid_in = 1'b1;
               state_in     = two_ff ? S_SEND1 : S_IDLE;
            end
         end
         S_SEND1: begin
            if (out_free) begin
               out_pt_in    = res_pt_ff[1];
               out_crop_in  = res_crop_ff[1];
               out_last_in  = res_last_ff[1];
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cut_ff       <= 1'b0;
         far_ff       <= 1'b0;
         run_ff       <= '0;
         crop_ff      <= '0;
         out_valid_ff <= 1'b0;
         two_ff       <= 1'b0;
         for (int a = 0; a < NA; a++) begin
            prev_ff[a] <= '0;
            end_ff[a]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cut_ff       <= cut_in;
         far_ff       <= far_in;
         run_ff       <= run_in;
         crop_ff      <= crop_in;
         out_valid_ff <= out_valid_in;
         two_ff       <= two_in;
         prev_ff      <= prev_in;
         end_ff       <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      d_ff        <= d_in;
      rem_ff      <= rem_in;
      last_ff     <= last_in;
      acc_ff      <= acc_in;
      rad_ff      <= rad_in;
      prod_ff     <= prod_in;
      root_ff     <= root_in;
      rrem_ff     <= rrem_in;
      cnt_ff      <= cnt_in;
      axis_ff     <= axis_in;
      part_ff     <= part_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      res_pt_ff   <= res_pt_in;
      res_crop_ff <= res_crop_in;
      res_last_ff <= res_last_in;
      out_pt_ff   <= out_pt_in;
      out_crop_ff <= out_crop_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_x         = out_pt_ff[0];
   assign rsp_out_y         = out_pt_ff[1];
   assign rsp_out_z         = out_pt_ff[2];
   assign rsp_is_crop_point = out_crop_ff;
   assign rsp_out_last      = out_last_ff;

   `CHECK_ALWAYS(a_state_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
   `CHECK_IMPLY(a_rem_below_seg, clock, reset, (state_ff == S_DECIDE) && take_cut, (K+1)'(rem_c) < (K+1)'(root_ff), "crop remainder not below segment length")
   `CHECK_IMPLY(a_offset_bound, clock, reset, state_ff == S_OFF_MUL, quo_ff <= mag_sel, "crop offset exceeds axis difference")
   `CHECK_IMPLY(a_second_result, clock, reset, state_ff == S_SEND1, two_ff, "second result without a pair")

endmodule

/* rtl/polyline_arc_length_crop.sv */
// Top level: polyline crop at a given arc length
//
//   channel  direction  transaction
//   req_     in         one path vertex, path_end flag, crop length
//   rsp_     out        one output vertex, crop point flag, last flag
//
// Ordinary vertex: the back end finds the segment length with a digit-serial
// square root, and may send a second result. A cutting vertex also runs the
// bit-serial offset division of the three axes. First vertices and
// pass-through paths skip the arithmetic. Synchronous active-high reset;
// a two-entry queue lets intake go on while the back end works or rsp stalls.
`timescale 1ns / 1ps
module polyline_arc_length_crop #(
   parameter int COORD_WIDTH = plca_pkg::DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = plca_pkg::DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   input  logic signed [COORD_WIDTH-1:0] req_crop_length,
   input  logic                          req_path_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z,
   output logic                          rsp_is_crop_point,
   output logic                          rsp_out_last
);

   logic                          q_valid, q_ready;
   plca_pkg::item_ctl_type        q_ctl;
   logic signed [COORD_WIDTH-1:0] q_x, q_y, q_z, q_crop;

   plca_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .req_crop_length (req_crop_length),
      .req_path_end    (req_path_end),
      .q_valid         (q_valid),
      .q_ready         (q_ready),
      .q_ctl           (q_ctl),
      .q_x             (q_x),
      .q_y             (q_y),
      .q_z             (q_z),
      .q_crop          (q_crop)
   );

   plca_back #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_ready           (q_ready),
      .q_ctl             (q_ctl),
      .q_x               (q_x),
      .q_y               (q_y),
      .q_z               (q_z),
      .q_crop            (q_crop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_z         (rsp_out_z),
      .rsp_is_crop_point (rsp_is_crop_point),
      .rsp_out_last      (rsp_out_last)
   );

endmodule

/* tb/tb_polyline_arc_length_crop.sv */
// Testbench for polyline_arc_length_crop: directed paths, random paths, backpressure
`timescale 1ns / 1ps
module tb_polyline_arc_length_crop;

   localparam int  CW          = 32;
   localparam int  LIMIT       = 800000;
   localparam int  DRAIN_WAIT  = 400;
   localparam int  LONG_HOLD   = 600;
   localparam longint NEAR_LIM = 6554;
   localparam longint LEN_CAP  = 64'h7fff_ffff;
   localparam int  METER       = 65536;

   typedef struct {
      logic [CW-1:0] x, y, z;
      logic          crop_pt;
      logic          last;
   } vertex_out_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [CW-1:0] req_point_x = 0, req_point_y = 0, req_point_z = 0;
   logic signed [CW-1:0] req_crop_length = 0;
   logic req_path_end = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [CW-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_is_crop_point, rsp_out_last;

   polyline_arc_length_crop u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_x(req_point_x), .req_point_y(req_point_y), .req_point_z(req_point_z),
      .req_crop_length(req_crop_length), .req_path_end(req_path_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
      .rsp_is_crop_point(rsp_is_crop_point), .rsp_out_last(rsp_out_last)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   vertex_out_type expected_vertices[$];
   int  errors = 0;
   int  cycles = 0;
   int  items_sent = 0;
   int  vertices_checked = 0;
   int  cuts_seen = 0;
   bit  long_hold = 0;
   bit  no_idle = 0;

   // predictor state
   longint prv_x, prv_y, prv_z;
   longint run_len, crop_held;
   longint cut_pt[3], sent_pt[3];
   bit     first_vtx, cut_taken;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAIL polyline_arc_length_crop");
         $finish;
      end
   end

   function automatic logic [63:0] magn(longint d);
      return d < 0 ? 64'(-d) : 64'(d);
   endfunction

   function automatic logic [63:0] seg_len(longint dx, longint dy, longint dz);
      logic [127:0] sq, c;
      logic [63:0]  r;
      sq = 128'(magn(dx)) * 128'(magn(dx)) + 128'(magn(dy)) * 128'(magn(dy))
         + 128'(magn(dz)) * 128'(magn(dz));
      r = 0;
      for (int b = 56; b >= 0; b--) begin
         c = 128'(r | (64'd1 << b));
         if (c * c <= sq) r = c[63:0];
      end
      return r;
   endfunction

   function automatic longint cut_axis(longint base, longint d, logic [63:0] rem,
                                       logic [63:0] seg);
      logic [127:0] off;
      off = (128'(rem) * 128'(magn(d))) / 128'(seg);
      return d < 0 ? base - longint'(off[63:0]) : base + longint'(off[63:0]);
   endfunction

   function automatic void push_vertex(longint x, longint y, longint z, bit c, bit l);
      vertex_out_type v;
      v.x = x[CW-1:0]; v.y = y[CW-1:0]; v.z = z[CW-1:0];
      v.crop_pt = c; v.last = l;
      expected_vertices.insert(expected_vertices.size(), v);
   endfunction

   function automatic void start_next_path();
      first_vtx = 1; cut_taken = 0; run_len = 0;
   endfunction

   function automatic void predict_crop(logic signed [CW-1:0] ix, iy, iz, icrop,
                                        logic ilast);
      longint px, py, pz, dx, dy, dz;
      logic [63:0] seg, rem;
      bit far;
      px = ix; py = iy; pz = iz;
      if (first_vtx) begin
         crop_held = icrop;
         prv_x = px; prv_y = py; prv_z = pz;
         run_len = 0; cut_taken = 0; first_vtx = 0;
         if (ilast) begin
            push_vertex(px, py, pz, 0, 1);
            start_next_path();
         end
         return;
      end
      if (crop_held < 0) begin
         push_vertex(prv_x, prv_y, prv_z, 0, 0);
         if (ilast) begin
            push_vertex(px, py, pz, 0, 1);
            start_next_path();
         end else begin
            prv_x = px; prv_y = py; prv_z = pz;
         end
         return;
      end
      if (!cut_taken) begin
         dx = px - prv_x; dy = py - prv_y; dz = pz - prv_z;
         seg = seg_len(dx, dy, dz);
         if (64'(run_len) + seg > 64'(crop_held)) begin
            rem = 64'(crop_held) - 64'(run_len);
            sent_pt[0] = prv_x; sent_pt[1] = prv_y; sent_pt[2] = prv_z;
            cut_pt[0] = cut_axis(prv_x, dx, rem, seg);
            cut_pt[1] = cut_axis(prv_y, dy, rem, seg);
            cut_pt[2] = cut_axis(prv_z, dz, rem, seg);
            cut_taken = 1;
            cuts_seen++;
         end else begin
            run_len = run_len + longint'(seg);
            if (run_len > LEN_CAP) run_len = LEN_CAP;
            if (ilast) begin
               far = seg > 64'(NEAR_LIM);
               push_vertex(prv_x, prv_y, prv_z, 0, !far);
               if (far) push_vertex(px, py, pz, 0, 1);
               start_next_path();
               return;
            end
            push_vertex(prv_x, prv_y, prv_z, 0, 0);
            sent_pt[0] = prv_x; sent_pt[1] = prv_y; sent_pt[2] = prv_z;
            prv_x = px; prv_y = py; prv_z = pz;
            return;
         end
      end
      if (ilast) begin
         far = seg_len(cut_pt[0] - sent_pt[0], cut_pt[1] - sent_pt[1],
                       cut_pt[2] - sent_pt[2]) > 64'(NEAR_LIM);
         push_vertex(sent_pt[0], sent_pt[1], sent_pt[2], 0, !far);
         if (far) push_vertex(cut_pt[0], cut_pt[1], cut_pt[2], 1, 1);
         start_next_path();
      end
   endfunction

   function automatic int draw_gap();
      if (no_idle) return 0;
      return $urandom_range(0, 11);
   endfunction

   task automatic send_vertex(int x, int y, int z, int crop, bit last);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         @(negedge clock) req_valid <= 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_point_x <= x; req_point_y <= y; req_point_z <= z;
      req_crop_length <= crop; req_path_end <= last;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      predict_crop(x, y, z, crop, last);
      items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock) req_valid <= 0;
      wait (expected_vertices.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // receiver and checker
   initial begin
      vertex_out_type e;
      int gap;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready <= 0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold = 0;
         end
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         if (expected_vertices.size() == 0) begin
            $error("unexpected output vertex %h %h %h", rsp_out_x, rsp_out_y, rsp_out_z);
            errors++;
         end else begin
            e = expected_vertices.pop_front();
            vertices_checked++;
            if (rsp_out_x !== e.x) begin
               $error("out_x exp %h got %h", e.x, rsp_out_x); errors++;
            end
            if (rsp_out_y !== e.y) begin
               $error("out_y exp %h got %h", e.y, rsp_out_y); errors++;
            end
            if (rsp_out_z !== e.z) begin
               $error("out_z exp %h got %h", e.z, rsp_out_z); errors++;
            end
            if (rsp_is_crop_point !== e.crop_pt) begin
               $error("is_crop_point exp %b got %b", e.crop_pt, rsp_is_crop_point);
               errors++;
            end
            if (rsp_out_last !== e.last) begin
               $error("out_last exp %b got %b", e.last, rsp_out_last); errors++;
            end
         end
      end
   end

   task automatic test_single_vertex();
      send_vertex(32'h7fff_ffff, 32'h8000_0000, 0, 5 * METER, 1);
      send_vertex(32'h8000_0000, 32'h7fff_ffff, -1, -1, 1);
      drain_results();
   endtask

   task automatic test_negative_crop();
      send_vertex(0, 0, 0, 32'h8000_0000, 0);
      send_vertex(METER, 0, 0, 0, 0);
      send_vertex(METER, METER, 0, 0, 0);
      send_vertex(METER, METER, 32'h7fff_ffff, 0, 1);
      drain_results();
   endtask

   task automatic test_zero_crop();
      send_vertex(METER, 2 * METER, 3 * METER, 0, 0);
      send_vertex(4 * METER, 2 * METER, 3 * METER, 0, 0);
      send_vertex(5 * METER, 2 * METER, 3 * METER, 0, 1);
      drain_results();
   endtask

   task automatic test_zero_segments();
      // repeated vertices add nothing; also path ending inside the crop length
      send_vertex(METER, METER, METER, 10 * METER, 0);
      send_vertex(METER, METER, METER, 0, 0);
      send_vertex(2 * METER, METER, METER, 0, 0);
      send_vertex(2 * METER, METER, METER, 0, 1);
      send_vertex(0, 0, 0, 10 * METER, 0);
      send_vertex(METER, 0, 0, 0, 0);
      send_vertex(METER + 100, 0, 0, 0, 1);
      drain_results();
   endtask

   task automatic test_extremes();
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0);
      send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
      send_vertex(0, 0, 0, 0, 1);
      send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
      send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 1);
      drain_results();
   endtask

   task automatic test_cut_near_vertex();
      // cut point within 0.1 m of the held vertex: no crop point appended
      send_vertex(0, 0, 0, METER / 20, 0);
      send_vertex(METER, 0, 0, 0, 0);
      send_vertex(2 * METER, 0, 0, 0, 1);
      // cut far from the held vertex, with an ignored vertex after it
      send_vertex(0, 0, 0, 3 * METER / 2, 0);
      send_vertex(0, METER, 0, 0, 0);
      send_vertex(0, METER, -2 * METER, 0, 0);
      send_vertex(5 * METER, 5 * METER, 5 * METER, 0, 1);
      drain_results();
   endtask

   task automatic send_random_path();
      int n, x, y, z, crop, r;
      n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 7);
      r = $urandom_range(0, 19);
      crop = r == 0 ? -$urandom_range(1, 10 * METER) : r == 1 ? 0 :
             r == 2 ? $urandom : $urandom_range(0, 12 * METER);
      x = $urandom_range(0, 20 * METER) - 10 * METER;
      y = $urandom_range(0, 20 * METER) - 10 * METER;
      z = $urandom_range(0, 4 * METER) - 2 * METER;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 29);
         if (i > 0) begin
            if (r == 0) begin
               x = $urandom; y = $urandom; z = $urandom;
            end else if (r == 1) begin
               x = x + $urandom_range(0, 2 * METER / 10) - METER / 10;
            end else if (r > 2) begin
               x = x + $urandom_range(0, 6 * METER) - 3 * METER;
               y = y + $urandom_range(0, 6 * METER) - 3 * METER;
               z = z + $urandom_range(0, METER) - METER / 2;
            end
         end
         send_vertex(x, y, z, i == 0 ? crop : $urandom, i == n - 1);
      end
   endtask

   task automatic test_pressure();
      long_hold = 1;
      for (int i = 0; i < 6; i++) send_random_path();
      drain_results();
   endtask

   task automatic test_random();
      while (items_sent < 620) begin
         no_idle = ($urandom_range(0, 5) == 0);
         send_random_path();
      end
      no_idle = 0;
      drain_results();
   endtask

   initial begin
      start_next_path();
      prv_x = 0; prv_y = 0; prv_z = 0; crop_held = 0;
      for (int k = 0; k < 3; k++) begin
         cut_pt[k] = 0; sent_pt[k] = 0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 0;
      test_single_vertex();
      test_negative_crop();
      test_zero_crop();
      test_zero_segments();
      test_extremes();
      test_cut_near_vertex();
      test_pressure();
      test_random();
      $display("Sent %0d vertices, checked %0d output vertices, %0d paths cut.",
               items_sent, vertices_checked, cuts_seen);
      $display("Covered single-vertex, negative, zero and extreme crops, plus stalls.");
      if (errors == 0 && expected_vertices.size() == 0) begin
         $display("PASS polyline_arc_length_crop");
      end else begin
         $display("FAIL polyline_arc_length_crop");
      end
      $finish;
   end

endmodule
